[rtl/greedy_longest_match_tokenizer_top_assert.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef GREEDY_LONGEST_MATCH_TOKENIZER_TOP_ASSERT_SVH
`define GREEDY_LONGEST_MATCH_TOKENIZER_TOP_ASSERT_SVH

// Implication checked every clock, disabled during reset.
`define GLMT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define GLMT_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

[rtl/glmt_pkg.sv]
//------------------------------------------------------------------------------
// glmt_pkg
// Shared types and codes for the greedy longest-match tokenizer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package glmt_pkg;
    // Vocabulary geometry; the port widths are sized for these values.
    localparam int VOCAB_ENTRIES = 1024;
    localparam int SLOT_BYTES    = 32;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_TEXT   = 2'd1;
    localparam logic [1:0] FUNC_END    = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_MATCH = 2'd1;
    localparam logic [1:0] KIND_RAW   = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [1:0] REG_LIMIT   = 2'd0;
    localparam logic [1:0] REG_BEGIN   = 2'd1;
    localparam logic [1:0] REG_ENTRIES = 2'd2;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_ADDR,
        ST_SCAN_DATA,
        ST_EMIT,
        ST_SHIFT,
        ST_END_LOOP,
        ST_END_MARK,
        ST_OUT_WAIT
    } t_state;
endpackage
`default_nettype wire

[rtl/greedy_longest_match_tokenizer_top.sv]
//------------------------------------------------------------------------------
// greedy_longest_match_tokenizer_top
// Greedy longest-match tokenizer over a vocabulary memory.
//------------------------------------------------------------------------------
// Usage: items enter on i_valid/o_stall with i_func, i_entry_index, i_byte_pos
// and i_byte_value. A load or a text byte that leaves the window short of full
// is taken without a scan. When the window fills, and at end of text, one
// token is chosen by scanning the vocabulary memory entry by entry; every byte
// read takes an address state, then a data state, and an entry is read up to
// its first mismatch or terminator, at most SLOT_BYTES-1 bytes. The scan goes
// over entries_in_use entries and keeps the longest match; the token is then
// emitted and the window shifted. End of text repeats this for each token left
// in the window, then sends the end marker, whose token is the count of tokens.
// Results leave on o_valid/i_stall through one output register; while the
// receiver stalls, the block holds that result and waits before going on.
// The input stalls while an item is worked on or a result waits. Configuration
// is written on i_cfg_valid/o_cfg_ready, always ready. Reset clears the window
// fill, token count and begin flag and loads the register reset values; the
// vocabulary memory is not cleared and must be loaded before use.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_longest_match_tokenizer_top_assert.svh"
module greedy_longest_match_tokenizer_top
    import glmt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [9:0]  i_entry_index,
    input  wire logic [4:0]  i_byte_pos,
    input  wire logic [7:0]  i_byte_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_token,
    output logic [1:0]       o_kind,
    output logic             o_final_res,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int WIN = SLOT_BYTES - 1;
    localparam int EW  = (VOCAB_ENTRIES > 1) ? $clog2(VOCAB_ENTRIES) : 1;
    localparam int BW  = $clog2(SLOT_BYTES);
    localparam int FW  = $clog2(SLOT_BYTES);
    localparam int CW  = EW + 1;

    logic [7:0] mem [VOCAB_ENTRIES*SLOT_BYTES];
    logic [7:0] r_rd;

    logic [15:0] r_limit, r_begin;
    logic [10:0] r_entries;

    logic [7:0]  r_win [WIN];
    logic [FW-1:0] r_fill;
    logic [15:0] r_count;
    logic        r_sent;

    t_state r_st, n_st;
    logic [CW-1:0] r_e;
    logic [BW-1:0] r_b;
    logic [FW-1:0] r_top_len;
    logic [EW-1:0] r_best_id;
    logic          r_ok;
    logic          r_end;

    logic        r_ov;
    logic [15:0] r_tok;
    logic [1:0]  r_kind;
    logic        r_fin;

    logic        acc;
    logic        text_acc;
    logic        ov_load;
    logic [CW-1:0] scan_cnt;
    logic [EW+BW-1:0] rd_addr;
    logic        out_free;

    assign o_cfg_ready = 1'b1;
    assign o_stall = (r_st != ST_IDLE) || r_ov;
    assign acc = i_valid && !o_stall;
    assign text_acc = acc && (i_func == FUNC_TEXT || i_func == FUNC_END);
    assign out_free = !r_ov || !i_stall;
    // The output register takes a begin token, a scan result or the end marker.
    assign ov_load = (r_st == ST_IDLE && text_acc && !r_sent && r_count < r_limit)
                     || ((r_st == ST_EMIT || r_st == ST_END_MARK) && out_free);
    assign o_valid = r_ov;
    assign o_token = r_tok;
    assign o_kind = r_kind;
    assign o_final_res = r_fin;
    assign scan_cnt = (r_entries > 11'(VOCAB_ENTRIES)) ? CW'(VOCAB_ENTRIES)
                                                       : CW'(r_entries);
    assign rd_addr = {r_e[EW-1:0], r_b};

    always_ff @(posedge i_clk) begin
        if (acc && i_func == FUNC_LOAD && i_byte_pos < 5'(WIN)
                && 32'(i_entry_index) < VOCAB_ENTRIES)
            mem[{i_entry_index[EW-1:0], i_byte_pos[BW-1:0]}] <= i_byte_value;
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 16'd512;
            r_begin <= 16'd1;
            r_entries <= 11'd1024;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LIMIT:   r_limit <= i_cfg_data;
                REG_BEGIN:   r_begin <= i_cfg_data;
                REG_ENTRIES: r_entries <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: ;
            ST_SCAN_ADDR: n_st = (r_e >= scan_cnt) ? ST_EMIT : ST_SCAN_DATA;
            ST_SCAN_DATA: n_st = ST_SCAN_ADDR;
            ST_EMIT: if (out_free) n_st = ST_SHIFT;
            ST_SHIFT: n_st = r_end ? ST_END_LOOP : ST_IDLE;
            ST_END_LOOP: n_st = (r_fill != '0 && r_count < r_limit)
                                ? ST_SCAN_ADDR : ST_END_MARK;
            ST_END_MARK: if (out_free) n_st = ST_OUT_WAIT;
            ST_OUT_WAIT: n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
        if (r_st == ST_IDLE && text_acc) begin
            if (i_func == FUNC_END || i_byte_value == 8'd0) n_st = ST_END_LOOP;
            else if (r_count + 16'(!r_sent && r_limit != 0) < r_limit
                     && r_fill == FW'(WIN - 1))
                n_st = ST_SCAN_ADDR;
        end
    end

    // Scan datapath, window and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_fill <= '0;
            r_count <= '0;
            r_sent <= 1'b0;
            r_ov <= 1'b0;
            r_end <= 1'b0;
        end else begin
            r_st <= n_st;
            if (ov_load) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (n_st == ST_SCAN_ADDR && r_st != ST_SCAN_DATA) begin
                r_e <= '0;
                r_b <= '0;
                r_ok <= 1'b1;
                r_top_len <= '0;
                r_best_id <= '0;
            end
            case (r_st)
                ST_IDLE: if (text_acc) begin
                    r_end <= (i_func == FUNC_END || i_byte_value == 8'd0);
                    if (!r_sent) begin
                        r_sent <= 1'b1;
                        if (r_count < r_limit) begin
                            r_tok <= r_begin;
                            r_kind <= KIND_BEGIN;
                            r_fin <= 1'b0;
                            r_count <= r_count + 16'd1;
                        end
                    end
                    if (i_func == FUNC_TEXT && i_byte_value != 8'd0
                            && r_count + 16'(!r_sent && r_limit != 0) < r_limit) begin
                        r_win[r_fill] <= i_byte_value;
                        r_fill <= r_fill + FW'(1);
                    end
                end
                ST_SCAN_DATA: begin
                    // r_rd is byte r_b of entry r_e; r_ok says whether the r_b bytes before it matched.
                    if (r_rd == 8'd0 || !r_ok || r_b >= BW'(r_fill)) begin
                        // String ends here, an earlier byte mismatched, or it cannot fit the window.
                        if (r_rd == 8'd0 && r_ok && r_b != '0
                                && FW'(r_b) > r_top_len) begin
                            r_top_len <= FW'(r_b);
                            r_best_id <= r_e[EW-1:0];
                        end
                        r_e <= r_e + CW'(1);
                        r_b <= '0;
                        r_ok <= 1'b1;
                    end else if (r_b == BW'(WIN - 1)) begin
                        if (r_ok && r_rd == r_win[r_b] && FW'(WIN) > r_top_len) begin
                            r_top_len <= FW'(WIN);
                            r_best_id <= r_e[EW-1:0];
                        end
                        r_e <= r_e + CW'(1);
                        r_b <= '0;
                        r_ok <= 1'b1;
                    end else begin
                        r_ok <= (r_rd == r_win[r_b]);
                        r_b <= r_b + BW'(1);
                    end
                end
                ST_EMIT: if (out_free) begin
                    r_fin <= 1'b0;
                    r_count <= r_count + 16'd1;
                    if (r_top_len != '0) begin
                        r_tok <= 16'(r_best_id);
                        r_kind <= KIND_MATCH;
                    end else begin
                        r_tok <= {8'd0, r_win[0]};
                        r_kind <= KIND_RAW;
                        r_top_len <= FW'(1);
                    end
                end
                ST_SHIFT: begin
                    for (int i = 0; i < WIN; i++)
                        if (i + int'(r_top_len) < WIN)
                            r_win[i] <= r_win[i + int'(r_top_len)];
                    r_fill <= r_fill - r_top_len;
                end
                ST_END_MARK: if (out_free) begin
                    r_tok <= r_count;
                    r_kind <= KIND_END;
                    r_fin <= 1'b1;
                    r_fill <= '0;
                    r_count <= '0;
                    r_sent <= 1'b0;
                    r_end <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    `GLMT_ASSERT_IMP(a_no_acc_busy, i_clk, i_rst_n, r_st != ST_IDLE, o_stall)
    `GLMT_ASSERT_IMP(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill < FW'(WIN) || r_st != ST_IDLE)
    `GLMT_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n,
        r_st == ST_END_MARK && out_free, r_fin && r_ov && r_count == 16'd0)
endmodule
`default_nettype wire
